/* design/vrb_pkg.sv */
// Shared types and constants for the vertical two-to-one height reducer.
package vrb_pkg;

    // Width of the configuration registers and of the source row counter.
    localparam int CFG_WIDTH = 13;

    // Width of the sample ports.
    localparam int PORT_BITS = 16;

    // Largest number of output rows.
    localparam logic [CFG_WIDTH-1:0] ROWS_LIMIT = CFG_WIDTH'(4096);

    // Register indexes of the configuration port.
    typedef enum logic [0:0] {
        REG_LINE_WIDTH = 1'b0,
        REG_OUT_ROWS   = 1'b1
    } t_reg_index;

    // What a source row does with its samples.
    typedef enum logic [1:0] {
        ROW_STORE_EVEN,
        ROW_STORE_ODD,
        ROW_FILTER,
        ROW_FINAL
    } t_row_kind;

    // Per-request control passed from the counters to the filter stage.
    typedef struct packed {
        t_row_kind kind;
        logic      row_end;
        logic      frame_end;
    } t_row_ctl;

endpackage

/* design/vrb_line_store.sv */
// Single-port line store with registered read data, read before write.
module vrb_line_store #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // The old entry is read out in the same cycle that a new one is written.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata <= r_mem[i_addr];
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/vrb_counters.sv */
// Column and source row counters that classify each accepted request.
module vrb_counters #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic [vrb_pkg::CFG_WIDTH-1:0]     i_line_width,
    input  logic [vrb_pkg::CFG_WIDTH-1:0]     i_out_rows,
    output logic [$clog2(MAX_WIDTH)-1:0]      o_col,
    output logic [vrb_pkg::CFG_WIDTH-1:0]     o_row,
    output vrb_pkg::t_row_ctl                 o_ctl
);

    import vrb_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW + 1 > CFG_WIDTH) ? CW + 1 : CFG_WIDTH;

    logic [CW-1:0]        r_col;
    logic [CFG_WIDTH-1:0] r_row;
    logic [WW-1:0]        w_lw_ext;
    logic [WW-1:0]        w_eff_width;
    logic [CFG_WIDTH-1:0] w_eff_rows;
    logic [CFG_WIDTH-1:0] w_last_row;
    logic                 w_last_col;
    logic                 w_final_row;

    // Clamp the registers to their usable ranges; zero acts as one.
    assign w_lw_ext = WW'(i_line_width);

    always_comb begin
        if (w_lw_ext == '0) begin
            w_eff_width = WW'(1);
        end else if (w_lw_ext > WW'(MAX_WIDTH)) begin
            w_eff_width = WW'(MAX_WIDTH);
        end else begin
            w_eff_width = w_lw_ext;
        end
        if (i_out_rows == '0) begin
            w_eff_rows = CFG_WIDTH'(1);
        end else if (i_out_rows > ROWS_LIMIT) begin
            w_eff_rows = ROWS_LIMIT;
        end else begin
            w_eff_rows = i_out_rows;
        end
    end

    // Final source row is twice the output rows less one, modulo the counter.
    assign w_last_row  = {w_eff_rows[CFG_WIDTH-2:0], 1'b0} - CFG_WIDTH'(1);
    assign w_last_col  = WW'(r_col) >= (w_eff_width - WW'(1));
    assign w_final_row = r_row >= w_last_row;

    // Classify the current request.
    always_comb begin
        if (w_final_row) begin
            o_ctl.kind = ROW_FINAL;
        end else if (r_row[0]) begin
            o_ctl.kind = ROW_STORE_ODD;
        end else if (r_row[CFG_WIDTH-1:1] != '0) begin
            o_ctl.kind = ROW_FILTER;
        end else begin
            o_ctl.kind = ROW_STORE_EVEN;
        end
        o_ctl.row_end   = w_last_col;
        o_ctl.frame_end = w_last_col && w_final_row;
    end

    // Advance the raster position on every accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            if (w_last_col) begin
                r_col <= '0;
                if (w_final_row) begin
                    r_row <= '0;
                end else begin
                    r_row <= r_row + CFG_WIDTH'(1);
                end
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    assign o_col = r_col;
    assign o_row = r_row;

endmodule

/* design/vrb_filter.sv */
// Filter stage and output register with the downstream handshake.
module vrb_filter #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  logic [SAMPLE_BITS-1:0]         i_cur,
    input  vrb_pkg::t_row_ctl              i_ctl,
    input  logic [SAMPLE_BITS-1:0]         i_even,
    input  logic [SAMPLE_BITS-1:0]         i_odd,
    input  logic                           i_stall,
    output logic                           o_busy,
    output logic                           o_valid,
    output logic [vrb_pkg::PORT_BITS-1:0]  o_out_sample,
    output logic                           o_row_end,
    output logic                           o_frame_end
);

    import vrb_pkg::*;

    localparam int SUM_BITS = SAMPLE_BITS + 2;

    logic                   r_s1_valid;
    logic [SAMPLE_BITS-1:0] r_s1_cur;
    t_row_ctl               r_s1_ctl;
    logic                   r_out_valid;
    logic [PORT_BITS-1:0]   r_out_sample;
    logic                   r_out_row_end;
    logic                   r_out_frame_end;
    logic                   w_emit;
    logic                   w_s1_adv;
    logic [SAMPLE_BITS-1:0] w_mid;
    logic [SUM_BITS-1:0]    w_sum;

    // Only filtering and final rows produce a result.
    assign w_emit   = (i_ctl.kind == ROW_FILTER) || (i_ctl.kind == ROW_FINAL);
    assign w_s1_adv = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_busy   = r_s1_valid && !w_s1_adv;

    // The final row weights the current sample three times instead of odd twice.
    assign w_mid = (r_s1_ctl.kind == ROW_FINAL) ? r_s1_cur : i_odd;
    assign w_sum = SUM_BITS'(i_even) + {1'b0, w_mid, 1'b0} + SUM_BITS'(r_s1_cur)
                 + SUM_BITS'(2);

    // Request held while its line store reads complete.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_load) begin
            r_s1_valid <= w_emit;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s1_cur <= i_cur;
            r_s1_ctl <= i_ctl;
        end
    end

    // Output register towards the receiver.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_sample    <= PORT_BITS'(w_sum[SUM_BITS-1:2]);
            r_out_row_end   <= r_s1_ctl.row_end;
            r_out_frame_end <= r_s1_ctl.frame_end;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_sample = r_out_sample;
    assign o_row_end    = r_out_row_end;
    assign o_frame_end  = r_out_frame_end;

endmodule

/* design/vertical_reduce_by_two.sv */
// Top level of the vertical two-to-one height reducer with a 1-2-1 filter.
//
// Source samples of one plane enter in raster order on i_sample with i_valid;
// the block holds them off with o_stall. A frame is 2*out_rows rows of
// line_width samples. Even rows from the third on, and the final row, each
// give one filtered sample per column on o_out_sample with o_valid; the
// receiver holds results with i_stall. o_row_end marks the last sample of an
// output row and o_frame_end the last sample of the frame.
// A result reaches the output register through the request register: the line
// store read and the request load share the accepting edge, and the filter add
// fills the output register once it is free of a stalled result.
// Throughput is one request per cycle while the receiver does not stall, set by
// the single-port line stores, each read and written once per request.
// When the receiver stalls, the output register and one request in flight
// are held and o_stall rises until the output register frees.
// Reset clears the column and row counters, empties the pipeline and sets
// line_width to 16 and out_rows to 3. Line store contents are undefined until
// the rows they hold have been received. The user must write configuration
// over APB while the block is idle, at byte addresses 0 and 4; not enforced.
module vertical_reduce_by_two #(
    parameter int MAX_WIDTH   = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [vrb_pkg::PORT_BITS-1:0]  i_sample,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [vrb_pkg::PORT_BITS-1:0]  o_out_sample,
    output logic                           o_row_end,
    output logic                           o_frame_end,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    import vrb_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic [CFG_WIDTH-1:0]   r_line_width;
    logic [CFG_WIDTH-1:0]   r_out_rows;
    logic                   w_cfg_write;
    logic                   w_reg_sel;
    logic                   w_accept;
    logic                   w_busy;
    logic [CW-1:0]          w_col;
    logic [CFG_WIDTH-1:0]   w_row;
    t_row_ctl               w_ctl;
    logic [SAMPLE_BITS-1:0] w_cur;
    logic                   w_even_we;
    logic                   w_odd_we;
    logic [SAMPLE_BITS-1:0] w_even_rd;
    logic [SAMPLE_BITS-1:0] w_odd_rd;

    // Configuration registers.
    assign pready      = 1'b1;
    assign w_reg_sel   = paddr[2];
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= CFG_WIDTH'(16);
            r_out_rows   <= CFG_WIDTH'(3);
        end else if (w_cfg_write) begin
            unique case (w_reg_sel)
                REG_LINE_WIDTH: r_line_width <= pwdata[CFG_WIDTH-1:0];
                REG_OUT_ROWS:   r_out_rows   <= pwdata[CFG_WIDTH-1:0];
                default:        r_out_rows   <= r_out_rows;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_sel)
            REG_LINE_WIDTH: prdata = 32'(r_line_width);
            REG_OUT_ROWS:   prdata = 32'(r_out_rows);
            default:        prdata = '0;
        endcase
    end

    // Input handshake.
    assign o_stall  = w_busy;
    assign w_accept = i_valid && !o_stall;
    assign w_cur    = i_sample[SAMPLE_BITS-1:0];

    vrb_counters #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_counters (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_line_width (r_line_width),
        .i_out_rows   (r_out_rows),
        .o_col        (w_col),
        .o_row        (w_row),
        .o_ctl        (w_ctl)
    );

    // Even rows, including the filtering ones, replace the even line.
    assign w_even_we = (w_ctl.kind == ROW_STORE_EVEN) || (w_ctl.kind == ROW_FILTER);
    assign w_odd_we  = (w_ctl.kind == ROW_STORE_ODD);

    vrb_line_store #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (SAMPLE_BITS)
    ) u_even_store (
        .i_clk   (i_clk),
        .i_en    (w_accept),
        .i_we    (w_even_we),
        .i_addr  (w_col),
        .i_wdata (w_cur),
        .o_rdata (w_even_rd)
    );

    vrb_line_store #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (SAMPLE_BITS)
    ) u_odd_store (
        .i_clk   (i_clk),
        .i_en    (w_accept),
        .i_we    (w_odd_we),
        .i_addr  (w_col),
        .i_wdata (w_cur),
        .o_rdata (w_odd_rd)
    );

    vrb_filter #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_filter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_accept),
        .i_cur        (w_cur),
        .i_ctl        (w_ctl),
        .i_even       (w_even_rd),
        .i_odd        (w_odd_rd),
        .i_stall      (i_stall),
        .o_busy       (w_busy),
        .o_valid      (o_valid),
        .o_out_sample (o_out_sample),
        .o_row_end    (o_row_end),
        .o_frame_end  (o_frame_end)
    );

    // A frame always ends on the last sample of a row.
    a_frame_end_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_frame_end || o_row_end))
        else $error("frame end without row end");

    // The column counter returns to zero after the last sample of a row.
    a_col_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_ctl.row_end) |=> (w_col == '0))
        else $error("column counter did not wrap");

    // The row counter returns to zero after the last sample of the frame.
    a_row_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_ctl.frame_end) |=> (w_row == '0))
        else $error("row counter did not wrap");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule
